/* hw/rtl/ort_pkg.sv */
// package for the outstanding request table
// shared types, op and status codes; no dependencies
package ort_pkg;
  localparam int DEPTH_DEF = 32;
  localparam int PW = 16;
  localparam int BW = 24;
  localparam int LW = 18;
  localparam int TW = 32;
  localparam int RW = 8;
  localparam int CNTW = 6;
  localparam int POSW = 5;

  typedef enum logic [3:0] {
    OP_APPEND = 4'd0, OP_INSERT = 4'd1, OP_FIND = 4'd2, OP_REMKEY = 4'd3,
    OP_REMPOS = 4'd4, OP_POP = 4'd5, OP_READ = 4'd6, OP_MAX = 4'd7, OP_MIN = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_NOT_FOUND = 3'd1, ST_FULL = 3'd2, ST_EMPTY = 3'd3,
    ST_RANGE = 3'd4
  } status_t;

  localparam logic CFG_MAX_SIZE = 1'b0;
  localparam logic CFG_CHECK_SIZE = 1'b1;

  typedef struct packed {
    logic [PW-1:0] piece;
    logic [BW-1:0] bbeg;
    logic [LW-1:0] len;
    logic [TW-1:0] tstamp;
    logic [RW-1:0] peer;
  } entry_t;

  typedef struct packed {
    logic shift_up;
    logic shift_down;
    logic load;
  } cell_ctl_t;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EXEC, S_OUT} state_t;
endpackage

/* hw/rtl/ort_if.sv */
// valid/ready channel interfaces
// depends on ort_pkg
interface ort_req_if;
  import ort_pkg::*;
  logic valid;
  logic ready;
  logic [3:0] op;
  logic [PW-1:0] piece_index;
  logic [BW-1:0] block_begin;
  logic [LW-1:0] block_length;
  logic [TW-1:0] timestamp;
  logic [RW-1:0] peer_tag;
  logic silent;
  logic [POSW-1:0] position;
  modport source (output valid, op, piece_index, block_begin, block_length, timestamp,
                  peer_tag, silent, position, input ready);
  modport sink (input valid, op, piece_index, block_begin, block_length, timestamp,
                peer_tag, silent, position, output ready);
endinterface

interface ort_rsp_if;
  import ort_pkg::*;
  logic valid;
  logic ready;
  logic [2:0] status;
  logic [POSW-1:0] found_position;
  logic [PW-1:0] piece_out;
  logic [BW-1:0] begin_out;
  logic [LW-1:0] length_out;
  logic [TW-1:0] time_out;
  logic [RW-1:0] peer_out;
  logic [CNTW-1:0] entry_count;
  logic can_request_more;
  modport source (output valid, status, found_position, piece_out, begin_out, length_out,
                  time_out, peer_out, entry_count, can_request_more, input ready);
  modport sink (input valid, status, found_position, piece_out, begin_out, length_out,
                time_out, peer_out, entry_count, can_request_more, output ready);
endinterface

interface ort_cfg_if;
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [5:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/ort_cell.sv */
// one table cell: holds an entry, shifts with its neighbors, compares against the key
// depends on ort_pkg
module ort_cell import ort_pkg::*; (
  input  logic          clk,
  input  cell_ctl_t     ctl,
  input  entry_t        from_lower,
  input  entry_t        from_upper,
  input  entry_t        load_data,
  input  logic [PW-1:0] key_piece,
  input  logic [BW-1:0] key_begin,
  output entry_t        entry,
  output logic          piece_hit,
  output logic          key_hit
);
  always_ff @(posedge clk) begin
    if (ctl.load) entry <= load_data;
    else if (ctl.shift_up) entry <= from_lower;
    else if (ctl.shift_down) entry <= from_upper;
  end
  assign piece_hit = entry.piece == key_piece;
  assign key_hit = piece_hit && entry.bbeg == key_begin;
endmodule

/* hw/rtl/outstanding_request_table_core.sv */
// top level of the outstanding request table: cell row, sequencer, output register
// depends on ort_pkg, ort_if, ort_cell
//
// channel  dir  payload
// req      in   op, key, entry fields, silent, position
// rsp      out  status, position, entry fields, entry_count, can_request_more
// cfg      in   index, data (max_size, check_size)
//
// each beat steps through accept, scan (registered match/min/max over the cells),
// execute (a load or one shift of the cell row), result register.
// the result register holds under stall; the next beat waits until it is taken.
// rst clears count and state and sets max_size to 32, check_size on; cell contents are not reset.
module outstanding_request_table_core import ort_pkg::*; #(
  parameter int TABLE_DEPTH = DEPTH_DEF
) (
  input logic clk,
  input logic rst,
  ort_req_if.sink req,
  ort_rsp_if.source rsp,
  ort_cfg_if.sink cfg
);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SP = 1 << IW;

  state_t state, state_next;
  logic [CW-1:0] count;
  logic [5:0] max_size;
  logic check_size;

  logic [3:0] op_r;
  entry_t in_r;
  logic silent_r;
  logic [POSW-1:0] pos_r;

  entry_t cells [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] phit, khit;
  cell_ctl_t ctl [TABLE_DEPTH];

  // scan results
  logic found;
  logic [IW-1:0] found_idx;
  logic seen;
  logic [BW-1:0] ext;
  logic [CW-1:0] tgt;
  logic tgt_ok;

  logic scan_f, scan_s;
  logic [IW-1:0] scan_fi;
  logic [BW-1:0] scan_m;

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : gcell
      entry_t lo, hi;
      if (g == 0) begin : glo
        assign lo = in_r;
      end else begin : glo
        assign lo = cells[g-1];
      end
      if (g == TABLE_DEPTH - 1) begin : ghi
        assign hi = cells[g];
      end else begin : ghi
        assign hi = cells[g+1];
      end
      ort_cell u_cell (
        .clk(clk), .ctl(ctl[g]), .from_lower(lo), .from_upper(hi), .load_data(in_r),
        .key_piece(in_r.piece), .key_begin(in_r.bbeg), .entry(cells[g]),
        .piece_hit(phit[g]), .key_hit(khit[g])
      );
    end
  endgenerate

  always_comb begin
    logic f;
    logic [IW-1:0] fi;
    logic tv [2*SP];
    logic [BW-1:0] tm [2*SP];
    f = 1'b0;
    fi = '0;
    for (int k = 0; k < 2*SP; k++) begin
      tv[k] = 1'b0;
      tm[k] = '0;
    end
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (k < int'(count)) begin
        if (khit[k] && !f) begin
          f = 1'b1;
          fi = IW'(k);
        end
        tv[SP+k] = phit[k];
        tm[SP+k] = cells[k].bbeg;
      end
    end
    // pairwise max/min tree over the cells holding the piece
    for (int n = SP - 1; n >= 1; n--) begin
      tv[n] = tv[2*n] || tv[2*n+1];
      if (!tv[2*n+1]) tm[n] = tm[2*n];
      else if (!tv[2*n]) tm[n] = tm[2*n+1];
      else if (op_r == OP_MAX) tm[n] = (tm[2*n+1] > tm[2*n]) ? tm[2*n+1] : tm[2*n];
      else tm[n] = (tm[2*n+1] < tm[2*n]) ? tm[2*n+1] : tm[2*n];
    end
    scan_f = f;
    scan_s = tv[1];
    scan_fi = fi;
    scan_m = tm[1];
  end

  logic full;
  assign full = (count >= CW'(TABLE_DEPTH)) ||
                (check_size && ({2'b0, count} >= (CW + 2)'(max_size)));

  // cell controls during execute
  always_comb begin
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      ctl[k] = '0;
      if (state == S_EXEC && tgt_ok) begin
        unique case (op_r)
          OP_APPEND: ctl[k].load = (k == int'(count)) && !full;
          OP_INSERT: begin
            ctl[k].shift_up = !full && (k <= int'(count));
          end
          OP_REMKEY, OP_REMPOS: ctl[k].shift_down = (k >= int'(tgt)) && (k < int'(count));
          default: ;
        endcase
      end
    end
  end

  logic [2:0] st;
  entry_t oe;
  logic give;
  always_comb begin
    st = ST_OK;
    give = 1'b0;
    unique case (op_r)
      OP_APPEND, OP_INSERT: if (full) st = ST_FULL;
      OP_FIND: if (!found) st = ST_NOT_FOUND;
      OP_REMKEY: if (!found && !silent_r && count != '0) st = ST_NOT_FOUND;
      OP_REMPOS, OP_READ: if (!tgt_ok) st = ST_RANGE; else give = (op_r == OP_READ);
      OP_POP: if (count == '0) st = ST_EMPTY; else give = 1'b1;
      OP_MAX, OP_MIN: if (!seen) st = ST_NOT_FOUND;
      default: ;
    endcase
  end
  assign oe = cells[tgt[IW-1:0]];

  logic [CW-1:0] count_next;
  always_comb begin
    count_next = count;
    unique case (op_r)
      OP_APPEND, OP_INSERT: if (!full) count_next = count + 1'b1;
      OP_REMKEY, OP_REMPOS: if (tgt_ok) count_next = count - 1'b1;
      OP_POP: if (count != '0) count_next = count - 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req.valid && req.ready) state_next = S_SCAN;
      S_SCAN: state_next = S_EXEC;
      S_EXEC: state_next = S_OUT;
      S_OUT: if (rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      max_size <= 6'd32;
      check_size <= 1'b1;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        if (cfg.index == CFG_MAX_SIZE) max_size <= cfg.data;
        else check_size <= cfg.data[0];
      end
      if (state == S_EXEC) count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      op_r <= req.op;
      in_r <= '{req.piece_index, req.block_begin, req.block_length, req.timestamp,
                req.peer_tag};
      silent_r <= req.silent;
      pos_r <= req.position;
    end
    if (state == S_SCAN) begin
      found <= scan_f;
      found_idx <= scan_fi;
      seen <= scan_s;
      ext <= scan_m;
      unique case (op_r)
        OP_REMKEY: begin
          tgt <= CW'(scan_fi);
          tgt_ok <= scan_f;
        end
        OP_POP: begin
          tgt <= count - 1'b1;
          tgt_ok <= 1'b0;
        end
        OP_REMPOS, OP_READ: begin
          tgt <= CW'(pos_r);
          tgt_ok <= {{(CW > POSW ? CW - POSW : 0){1'b0}}, pos_r} < (CW > POSW ? CW : POSW)'(count);
        end
        default: begin
          tgt <= '0;
          tgt_ok <= 1'b1;
        end
      endcase
    end
    if (state == S_EXEC) begin
      rsp.status <= st;
      rsp.found_position <= (op_r == OP_FIND && found) ? POSW'(found_idx) : '0;
      rsp.piece_out <= give ? oe.piece : '0;
      rsp.begin_out <= give ? oe.bbeg : ((op_r == OP_MAX || op_r == OP_MIN) && seen) ? ext : '0;
      rsp.length_out <= give ? oe.len : '0;
      rsp.time_out <= give ? oe.tstamp : '0;
      rsp.peer_out <= give ? oe.peer : '0;
      rsp.entry_count <= CNTW'(count_next);
      rsp.can_request_more <= ({2'b0, count_next} < (CW + 2)'(max_size));
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH)) else $error("count above depth");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !rsp.ready) |=> state == S_OUT) else $error("result dropped");
  a_no_accept: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !req.ready) else $error("accept while busy");
endmodule
